### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/cdp_pkg.sv
// ----------------------------------------------------------------------------
// cdp_pkg
// Types, codes and helpers shared by the constraint propagator modules.
// ----------------------------------------------------------------------------
package cdp_pkg;

  localparam int NUM_VARS = 16;
  localparam int NUM_CONS = 64;

  // Function codes of an input beat
  localparam logic [1:0] FUNC_LOAD_DOM  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_CONS = 2'd1;
  localparam logic [1:0] FUNC_RUN       = 2'd2;

  // Constraint kinds
  localparam logic [1:0] KIND_ALLDIFF = 2'd0;
  localparam logic [1:0] KIND_ONEOF   = 2'd1;
  localparam logic [1:0] KIND_EXACT   = 2'd2;
  localparam logic [1:0] KIND_ATMOST  = 2'd3;

  // Run status codes
  localparam logic [1:0] ST_SOLVED = 2'd0;
  localparam logic [1:0] ST_OPEN   = 2'd1;
  localparam logic [1:0] ST_UNSOLV = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // Config register indexes
  localparam logic CFG_VAR_COUNT  = 1'b0;
  localparam logic CFG_CONS_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  slot;
    logic [15:0] domain_mask;
    logic [1:0]  kind;
    logic [3:0]  target_value;
    logic [4:0]  needed_count;
    logic [15:0] member_mask;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  var_index;
    logic [15:0] final_mask;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  target;
    logic [4:0]  need;
    logic [15:0] members;
  } cons_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load_dom;
    logic load_cons;
    logic run_start;
    logic init_push;
    logic pop_rd;
    logic pop_take;
    logic latch_cur;
    logic count_step;
    logic alld_step;
    logic apply;
    logic k_clear;
    logic req_rd;
    logic req_ev;
    logic st_final;
    logic st_empty;
    logic st_unsolv;
    logic emit_step;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic nc_zero;
    logic last_i;
    logic last_k;
    logic depth_zero;
    logic any_empty;
    logic kind_alld;
    logic changed;
    logic dec_unsolv;
    logic dec_apply;
  } stat_t;

  function automatic logic is_single(input logic [15:0] d);
    is_single = (d != 16'd0) && ((d & (d - 16'd1)) == 16'd0);
  endfunction

endpackage

### rtl/cdp_ctrl.sv
// ----------------------------------------------------------------------------
// cdp_ctrl
// Sequencer for loads, work-list propagation and result emission.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_func,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  cdp_pkg::stat_t stat,
  output cdp_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_POPW   = 4'd3;
  localparam logic [3:0] S_CREAD  = 4'd4;
  localparam logic [3:0] S_COUNT  = 4'd5;
  localparam logic [3:0] S_ALLD   = 4'd6;
  localparam logic [3:0] S_DECIDE = 4'd7;
  localparam logic [3:0] S_REQRD  = 4'd8;
  localparam logic [3:0] S_REQEV  = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  logic [3:0] state_r, state_nxt;

  // Next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_func)
            cdp_pkg::FUNC_LOAD_DOM:  cmd.load_dom = 1'b1;
            cdp_pkg::FUNC_LOAD_CONS: cmd.load_cons = 1'b1;
            cdp_pkg::FUNC_RUN: begin
              cmd.run_start = 1'b1;
              state_nxt = stat.nc_zero ? S_CHECK : S_INIT;
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        cmd.init_push = 1'b1;
        if (stat.last_k) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.depth_zero) begin
          cmd.st_final = 1'b1;
          state_nxt = S_EMIT;
        end else if (stat.any_empty) begin
          cmd.st_empty = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        cmd.pop_take = 1'b1;
        state_nxt = S_CREAD;
      end
      S_CREAD: begin
        cmd.latch_cur = 1'b1;
        state_nxt = stat.kind_alld ? S_ALLD : S_COUNT;
      end
      S_COUNT: begin
        cmd.count_step = 1'b1;
        if (stat.last_i) state_nxt = S_DECIDE;
      end
      S_ALLD: begin
        cmd.alld_step = 1'b1;
        if (stat.last_i) begin
          if (stat.changed) begin
            cmd.k_clear = 1'b1;
            state_nxt = S_REQRD;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_DECIDE: begin
        if (stat.dec_unsolv) begin
          cmd.st_unsolv = 1'b1;
          state_nxt = S_EMIT;
        end else if (stat.dec_apply) begin
          cmd.apply   = 1'b1;
          cmd.k_clear = 1'b1;
          state_nxt = S_REQRD;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_REQRD: begin
        cmd.req_rd = 1'b1;
        state_nxt = S_REQEV;
      end
      S_REQEV: begin
        cmd.req_ev = 1'b1;
        state_nxt = stat.last_k ? S_CHECK : S_REQRD;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_step = 1'b1;
          if (stat.last_i) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Input and output sides are never open together
  `ASSERT_IMP(a_excl_hs, in_ready, !out_valid)

endmodule

### rtl/cdp_dp.sv
// ----------------------------------------------------------------------------
// cdp_dp
// Domains, constraint table, work stack, queued flags and revision logic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  cdp_pkg::in_item_t   in_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_wdata,
  input  cdp_pkg::cmd_t       cmd,
  output cdp_pkg::stat_t      stat,
  output cdp_pkg::out_item_t  out_data
);

  localparam int NV = cdp_pkg::NUM_VARS;
  localparam int NC = cdp_pkg::NUM_CONS;

  logic [4:0]  vc_r;
  logic [6:0]  cc_r;
  logic [3:0]  nvm1;
  logic [6:0]  nc;
  logic [15:0] use_mask;

  logic [15:0] dom_r   [NV];
  logic [15:0] dom_nxt [NV];

  cdp_pkg::cons_t cons_mem [NC];
  cdp_pkg::cons_t cons_q;
  logic [5:0]  stack_mem [NC];
  logic [5:0]  stack_q;
  logic [6:0]  depth_r;
  logic [NC-1:0] queued_r;

  logic [3:0]  i_r;
  logic [5:0]  k_r;
  logic [4:0]  h_r, s_r;
  logic        changed_r;
  logic [1:0]  status_r;
  logic [1:0]  kind_r;
  logic [3:0]  tgt_r;
  logic [4:0]  need_r;
  logic [15:0] mem_r;

  logic [15:0] tmask, di;
  logic        alld_hit, push, any_empty, any_open;
  logic        dec_unsolv, dec_apply;

  // Clamped counts
  always_comb begin
    if (vc_r == 5'd0)       nvm1 = 4'd0;
    else if (vc_r > 5'd16)  nvm1 = 4'd15;
    else                    nvm1 = 4'(vc_r - 5'd1);
    nc = (cc_r > 7'd64) ? 7'd64 : cc_r;
    for (int j = 0; j < NV; j++) use_mask[j] = (4'(j) <= nvm1);
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 5'd16;
      cc_r <= 7'd0;
    end else if (cfg_we) begin
      if (cfg_index == cdp_pkg::CFG_VAR_COUNT) vc_r <= cfg_wdata[4:0];
      else cc_r <= cfg_wdata;
    end
  end

  assign tmask = 16'd1 << tgt_r;
  assign di    = dom_r[i_r];

  // Domain updates: load, all-different elimination, forced assignment or target removal
  always_comb begin
    alld_hit = 1'b0;
    for (int j = 0; j < NV; j++) dom_nxt[j] = dom_r[j];
    if (cmd.load_dom && in_data.slot[5:4] == 2'd0)
      dom_nxt[in_data.slot[3:0]] = in_data.domain_mask;
    if (cmd.alld_step && mem_r[i_r] && cdp_pkg::is_single(di)) begin
      for (int j = 0; j < NV; j++) begin
        if (mem_r[j] && !cdp_pkg::is_single(dom_r[j]) && ((dom_r[j] & di) != 16'd0)) begin
          dom_nxt[j] = dom_r[j] & ~di;
          alld_hit = 1'b1;
        end
      end
    end
    if (cmd.apply) begin
      for (int j = 0; j < NV; j++) begin
        if (mem_r[j] && ((dom_r[j] & tmask) != 16'd0)) begin
          if (kind_r != cdp_pkg::KIND_ATMOST) dom_nxt[j] = tmask;
          else if (!cdp_pkg::is_single(dom_r[j])) dom_nxt[j] = dom_r[j] & ~tmask;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NV; j++) dom_r[j] <= dom_nxt[j];
  end

  // Empty / open scan over variables in use
  always_comb begin
    any_empty = 1'b0;
    any_open  = 1'b0;
    for (int j = 0; j < NV; j++) begin
      if (use_mask[j] && dom_r[j] == 16'd0) any_empty = 1'b1;
      if (use_mask[j] && dom_r[j] != 16'd0 && !cdp_pkg::is_single(dom_r[j])) any_open = 1'b1;
    end
  end

  // Revision decision from holder counts
  always_comb begin
    dec_unsolv = 1'b0;
    dec_apply  = 1'b0;
    case (kind_r)
      cdp_pkg::KIND_ONEOF: begin
        dec_unsolv = (h_r == 5'd0);
        dec_apply  = (h_r == 5'd1) && (s_r == 5'd0);
      end
      cdp_pkg::KIND_EXACT: begin
        dec_unsolv = (h_r < need_r);
        dec_apply  = (s_r != h_r) && (h_r == need_r);
      end
      cdp_pkg::KIND_ATMOST: begin
        dec_apply  = (h_r > need_r) && (s_r == need_r);
      end
      default: ;
    endcase
  end

  // Push on initial fill or on re-queue of a sharing constraint
  assign push = cmd.init_push ||
                (cmd.req_ev && ((cons_q.members & mem_r) != 16'd0) &&
                 !queued_r[k_r] && (depth_r < 7'd64));

  // Constraint table: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.load_cons) begin
      cons_mem[in_data.slot] <= '{kind: in_data.kind, target: in_data.target_value,
                                  need: in_data.needed_count, members: in_data.member_mask};
    end
    if (cmd.pop_take)    cons_q <= cons_mem[stack_q];
    else if (cmd.req_rd) cons_q <= cons_mem[k_r];
  end

  // Work stack memory
  always_ff @(posedge clk) begin
    if (push) stack_mem[depth_r[5:0]] <= k_r;
    if (cmd.pop_rd) stack_q <= stack_mem[6'(depth_r - 7'd1)];
  end

  // Stack depth, queued flags, counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= '0;
      queued_r <= '0;
      k_r      <= '0;
      i_r      <= '0;
      status_r <= cdp_pkg::ST_SOLVED;
    end else begin
      if (cmd.run_start) begin
        depth_r  <= '0;
        queued_r <= '0;
      end else if (push) begin
        depth_r <= depth_r + 7'd1;
        queued_r[k_r] <= 1'b1;
      end else if (cmd.pop_rd) begin
        depth_r <= depth_r - 7'd1;
      end else if (cmd.pop_take) begin
        queued_r[stack_q] <= 1'b0;
      end

      if (cmd.run_start || cmd.k_clear)       k_r <= '0;
      else if (cmd.init_push || cmd.req_ev)   k_r <= k_r + 6'd1;

      if (cmd.latch_cur || cmd.st_final || cmd.st_empty || cmd.st_unsolv)
        i_r <= '0;
      else if (cmd.count_step || cmd.alld_step || cmd.emit_step)
        i_r <= i_r + 4'd1;

      if (cmd.st_empty)       status_r <= cdp_pkg::ST_EMPTY;
      else if (cmd.st_unsolv) status_r <= cdp_pkg::ST_UNSOLV;
      else if (cmd.st_final)
        status_r <= any_empty ? cdp_pkg::ST_EMPTY :
                    (any_open ? cdp_pkg::ST_OPEN : cdp_pkg::ST_SOLVED);
    end
  end

  // Current constraint and revision accumulators
  always_ff @(posedge clk) begin
    if (cmd.latch_cur) begin
      kind_r    <= cons_q.kind;
      tgt_r     <= cons_q.target;
      need_r    <= cons_q.need;
      mem_r     <= cons_q.members & use_mask;
      h_r       <= '0;
      s_r       <= '0;
      changed_r <= 1'b0;
    end else begin
      if (cmd.count_step && mem_r[i_r] && ((di & tmask) != 16'd0)) begin
        h_r <= h_r + 5'd1;
        if (cdp_pkg::is_single(di)) s_r <= s_r + 5'd1;
      end
      if (alld_hit) changed_r <= 1'b1;
    end
  end

  // Status to controller
  always_comb begin
    stat.nc_zero    = (nc == 7'd0);
    stat.last_i     = (i_r == nvm1);
    stat.last_k     = ({1'b0, k_r} == 7'(nc - 7'd1));
    stat.depth_zero = (depth_r == 7'd0);
    stat.any_empty  = any_empty;
    stat.kind_alld  = (cons_q.kind == cdp_pkg::KIND_ALLDIFF);
    stat.changed    = changed_r || alld_hit;
    stat.dec_unsolv = dec_unsolv;
    stat.dec_apply  = dec_apply;
  end

  assign out_data.var_index  = i_r;
  assign out_data.final_mask = di;
  assign out_data.status     = status_r;
  assign out_data.last       = (i_r == nvm1);

  `ASSERT_IMP(a_no_pop_empty, cmd.pop_rd, depth_r != 7'd0)
  `ASSERT_IMP(a_push_room, push, depth_r < 7'd64)
  `ASSERT_NXT(a_push_grows, push && !cmd.run_start, depth_r == $past(depth_r) + 7'd1)

endmodule

### rtl/constraint_domain_propagator.sv
// ----------------------------------------------------------------------------
// constraint_domain_propagator
// Arc-consistency style propagator over 16 bitmask domains, 64 constraints.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, in_data) carries load and run beats.
//   A domain or constraint load yields no result beat.
//   A run beat fills the work list with every loaded constraint, then
//   pops and revises constraints one at a time: each pop reads the stack
//   and then the constraint table, scans the variables in use, and a
//   revision that changes a domain walks the loaded constraints to re-queue
//   neighbors. Run time is data dependent; the shared stack and table read
//   ports and the one-variable-per-cycle revision scan set it.
//   The result channel (out_valid/out_ready, out_data) then gives one beat
//   per variable in use, last set on the final one; a stalled receiver
//   simply holds the current beat. One item is handled at a time: in_ready
//   is low from a run beat until its last result beat is taken.
//   Config port (cfg_we, cfg_index, cfg_wdata) writes var_count (index 0)
//   and constraint_count (index 1); write only while idle (not enforced).
//   Reset (rst_n low, synchronous) returns to idle with var_count 16,
//   constraint_count 0 and an empty work list; domains and constraints
//   hold no defined value until loaded.
// ----------------------------------------------------------------------------
module constraint_domain_propagator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cdp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cdp_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_wdata
);

  cdp_pkg::cmd_t  cmd;
  cdp_pkg::stat_t stat;

  cdp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_data.func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cdp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

### sim/propagation_checker.sv
// ----------------------------------------------------------------------------
// propagation_checker
// Watches the load/run channel and the config port, rebuilds the domain
// propagation on its own copy of the store, and compares every reported
// domain beat against the oldest prediction.
// ----------------------------------------------------------------------------
module propagation_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  cdp_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  cdp_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_wdata,
  output int                 err_count,
  output int                 reports_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REV_SAME  = 2'd0;
  localparam logic [1:0] REV_SHRUNK = 2'd1;
  localparam logic [1:0] REV_FAIL  = 2'd2;

  logic [15:0]        dom_copy [cdp_pkg::NUM_VARS];
  cdp_pkg::cons_t     cons_copy [cdp_pkg::NUM_CONS];
  logic [4:0]         vars_reg;
  logic [6:0]         cons_reg;
  cdp_pkg::out_item_t report_q [$];

  function automatic bit one_hot16(logic [15:0] d);
    return (d != 16'd0) && ((d & (d - 16'd1)) == 16'd0);
  endfunction

  // One constraint revision against the domain copy
  function automatic logic [1:0] revise_cons(cdp_pkg::cons_t c, int nv);
    logic [15:0] t;
    logic [15:0] d;
    int holders;
    int singles;
    logic [1:0] res;
    t = 16'd1 << c.target;
    holders = 0;
    singles = 0;
    res = REV_SAME;
    for (int i = 0; i < nv; i++) begin
      if (c.members[i] && (dom_copy[i] & t) != 0) begin
        holders++;
        if (one_hot16(dom_copy[i])) singles++;
      end
    end
    case (c.kind)
      cdp_pkg::KIND_ALLDIFF: begin
        for (int i = 0; i < nv; i++) begin
          if (!c.members[i]) continue;
          d = dom_copy[i];
          if (!one_hot16(d)) continue;
          for (int j = 0; j < nv; j++) begin
            if (c.members[j] && !one_hot16(dom_copy[j]) && (dom_copy[j] & d) != 0) begin
              dom_copy[j] &= ~d;
              res = REV_SHRUNK;
            end
          end
        end
      end
      cdp_pkg::KIND_ONEOF: begin
        if (holders == 0) res = REV_FAIL;
        else if (holders == 1 && singles == 0) begin
          for (int i = 0; i < nv; i++)
            if (c.members[i] && (dom_copy[i] & t) != 0) dom_copy[i] = t;
          res = REV_SHRUNK;
        end
      end
      cdp_pkg::KIND_EXACT: begin
        if (holders < c.need) res = REV_FAIL;
        else if (singles == holders) res = REV_SAME;
        else if (holders == c.need) begin
          for (int i = 0; i < nv; i++)
            if (c.members[i] && (dom_copy[i] & t) != 0) dom_copy[i] = t;
          res = REV_SHRUNK;
        end
      end
      default: begin
        if (holders <= c.need) res = REV_SAME;
        else if (singles == c.need) begin
          for (int i = 0; i < nv; i++)
            if (c.members[i] && (dom_copy[i] & t) != 0 && !one_hot16(dom_copy[i]))
              dom_copy[i] &= ~t;
          res = REV_SHRUNK;
        end
      end
    endcase
    return res;
  endfunction

  // Full propagation run; queues one report per variable in use
  task automatic predict_run();
    int nv;
    int nc;
    int depth;
    int top;
    logic [5:0]  stack [cdp_pkg::NUM_CONS];
    bit          queued [cdp_pkg::NUM_CONS];
    logic [15:0] use_mask;
    logic [1:0]  st;
    logic [1:0]  r;
    bit done;
    bit open;
    bit empty;
    cdp_pkg::cons_t cur;
    cdp_pkg::out_item_t rep;
    nv = (vars_reg < 1) ? 1 :
         ((vars_reg > cdp_pkg::NUM_VARS) ? cdp_pkg::NUM_VARS : int'(vars_reg));
    nc = (cons_reg > cdp_pkg::NUM_CONS) ? cdp_pkg::NUM_CONS : int'(cons_reg);
    use_mask = (nv >= 16) ? 16'hFFFF : ((16'd1 << nv) - 16'd1);
    done = 0;
    st = cdp_pkg::ST_OPEN;
    depth = 0;
    foreach (queued[k]) queued[k] = 0;
    for (int k = 0; k < nc; k++) begin
      stack[depth++] = 6'(k);
      queued[k] = 1;
    end
    while (depth > 0 && !done) begin
      for (int i = 0; i < nv; i++)
        if (dom_copy[i] == 16'd0) done = 1;
      if (done) begin
        st = cdp_pkg::ST_EMPTY;
        break;
      end
      top = stack[--depth];
      queued[top] = 0;
      cur = cons_copy[top];
      cur.members &= use_mask;
      r = revise_cons(cur, nv);
      if (r == REV_FAIL) begin
        st = cdp_pkg::ST_UNSOLV;
        done = 1;
      end else if (r == REV_SHRUNK) begin
        for (int k = 0; k < nc; k++) begin
          if ((cons_copy[k].members & cur.members) != 0 && !queued[k] &&
              depth < cdp_pkg::NUM_CONS) begin
            stack[depth++] = 6'(k);
            queued[k] = 1;
          end
        end
      end
    end
    if (!done) begin
      open = 0;
      empty = 0;
      for (int i = 0; i < nv; i++) begin
        if (dom_copy[i] == 16'd0) empty = 1;
        else if (!one_hot16(dom_copy[i])) open = 1;
      end
      st = empty ? cdp_pkg::ST_EMPTY : (open ? cdp_pkg::ST_OPEN : cdp_pkg::ST_SOLVED);
    end
    for (int i = 0; i < nv; i++) begin
      rep.var_index  = 4'(i);
      rep.final_mask = dom_copy[i];
      rep.status     = st;
      rep.last       = (i + 1 == nv);
      report_q = {report_q, rep};
    end
  endtask

  always @(posedge clk) begin
    cdp_pkg::out_item_t exp_rep;
    if (!rst_n) begin
      vars_reg = 5'd16;
      cons_reg = 7'd0;
      err_count = 0;
      report_q.delete();
    end else begin
      // config writes
      if (cfg_we) begin
        if (cfg_index == cdp_pkg::CFG_VAR_COUNT) vars_reg = cfg_wdata[4:0];
        else cons_reg = cfg_wdata;
      end
      // accepted input beat
      if (in_valid && in_ready) begin
        case (in_data.func)
          cdp_pkg::FUNC_LOAD_DOM:
            if (in_data.slot < cdp_pkg::NUM_VARS)
              dom_copy[in_data.slot[3:0]] = in_data.domain_mask;
          cdp_pkg::FUNC_LOAD_CONS: begin
            cons_copy[in_data.slot].kind    = in_data.kind;
            cons_copy[in_data.slot].target  = in_data.target_value;
            cons_copy[in_data.slot].need    = in_data.needed_count;
            cons_copy[in_data.slot].members = in_data.member_mask;
          end
          cdp_pkg::FUNC_RUN: predict_run();
          default: ;
        endcase
      end
      // accepted result beat
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          $error("unexpected result beat var_index=%0d", out_data.var_index);
          err_count++;
        end else begin
          exp_rep = report_q.pop_front();
          if (out_data.var_index !== exp_rep.var_index) begin
            $error("var_index exp %0d got %0d", exp_rep.var_index, out_data.var_index);
            err_count++;
          end
          if (out_data.final_mask !== exp_rep.final_mask) begin
            $error("final_mask exp %h got %h", exp_rep.final_mask, out_data.final_mask);
            err_count++;
          end
          if (out_data.status !== exp_rep.status) begin
            $error("status exp %0d got %0d", exp_rep.status, out_data.status);
            err_count++;
          end
          if (out_data.last !== exp_rep.last) begin
            $error("last exp %0d got %0d", exp_rep.last, out_data.last);
            err_count++;
          end
        end
      end
    end
    reports_due = report_q.size();
  end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives domain/constraint loads, config settings and propagation runs into
// the propagator under varying back-pressure; the checker judges results.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_BEATS = 230;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int SETTLE = 40;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  cdp_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  cdp_pkg::out_item_t out_data;
  logic               cfg_we = 1'b0;
  logic               cfg_index = cdp_pkg::CFG_VAR_COUNT;
  logic [6:0]         cfg_wdata = '0;
  int                 err_count;
  int                 reports_due;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 rand_beats = 0;
  int                 cycles = 0;

  constraint_domain_propagator DUT (.*);

  propagation_checker u_checker (.*);

  initial forever #6 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // random filler for unused payload fields
  function automatic cdp_pkg::in_item_t rand_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return cdp_pkg::in_item_t'(r[$bits(cdp_pkg::in_item_t)-1:0]);
  endfunction

  // one beat; returns at the edge that accepts it
  task automatic send_beat(cdp_pkg::in_item_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    rand_beats++;
  endtask

  task automatic load_domain(logic [5:0] slot, logic [15:0] mask);
    cdp_pkg::in_item_t b;
    b = rand_item();
    b.func = cdp_pkg::FUNC_LOAD_DOM;
    b.slot = slot;
    b.domain_mask = mask;
    send_beat(b);
  endtask

  task automatic load_cons(logic [5:0] slot, logic [1:0] kind, logic [3:0] tgt,
                           logic [4:0] need, logic [15:0] members);
    cdp_pkg::in_item_t b;
    b = rand_item();
    b.func = cdp_pkg::FUNC_LOAD_CONS;
    b.slot = slot;
    b.kind = kind;
    b.target_value = tgt;
    b.needed_count = need;
    b.member_mask = members;
    send_beat(b);
  endtask

  task automatic run_prop();
    cdp_pkg::in_item_t b;
    b = rand_item();
    b.func = cdp_pkg::FUNC_RUN;
    send_beat(b);
  endtask

  // wait for quiet, then write one register
  task automatic write_cfg(logic idx, logic [6:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (reports_due == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int nv;
    int nc;
    logic [15:0] vmask;
    logic [6:0] cfg_v;
    cdp_pkg::in_item_t junk;
    bit paused;
    paused = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first phase: sender idles lightly, receiver heavily
    send_idle_pct = 23;
    recv_idle_pct = 84;

    // fill every domain and constraint so no run reads an unloaded entry
    for (int i = 0; i < cdp_pkg::NUM_VARS; i++) load_domain(6'(i), 16'hFFFF);
    for (int k = 0; k < cdp_pkg::NUM_CONS; k++)
      load_cons(6'(k), 2'($urandom), 4'($urandom), 5'($urandom_range(0, 3)), 16'($urandom));

    // directed: no constraints at reset settings
    run_prop();
    // all-different chain resolves to singletons
    load_domain(6'd0, 16'h0001);
    load_domain(6'd1, 16'h0003);
    load_domain(6'd2, 16'h0007);
    load_cons(6'd0, cdp_pkg::KIND_ALLDIFF, 4'd0, 5'd0, 16'hFFFF);
    write_cfg(cdp_pkg::CFG_VAR_COUNT, 7'd3);
    write_cfg(cdp_pkg::CFG_CONS_COUNT, 7'd1);
    run_prop();
    // one-of with no holder of the target is unsolvable
    load_cons(6'd0, cdp_pkg::KIND_ONEOF, 4'd15, 5'd0, 16'h0007);
    run_prop();
    // exactly sixteen and at-most zero
    load_domain(6'd0, 16'h8003);
    load_domain(6'd1, 16'h8001);
    load_cons(6'd0, cdp_pkg::KIND_EXACT, 4'd15, 5'd16, 16'h0003);
    run_prop();
    load_cons(6'd0, cdp_pkg::KIND_ATMOST, 4'd0, 5'd0, 16'h0007);
    run_prop();
    // empty domain, out-of-range slot, ignored func
    load_domain(6'd2, 16'h0000);
    load_domain(6'd63, 16'h0000);
    junk = rand_item();
    junk.func = 2'd3;
    send_beat(junk);
    run_prop();

    // random phases
    while (rand_beats < RAND_BEATS) begin
      if (rand_beats < RAND_BEATS / 3) begin
        send_idle_pct = 23; recv_idle_pct = 84;
      end else if (rand_beats < 2 * RAND_BEATS / 3) begin
        send_idle_pct = 84; recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      // settings, with the extremes now and then
      case ($urandom_range(9))
        0: cfg_v = 7'd0;
        1: cfg_v = 7'd31;
        2: cfg_v = 7'd16;
        default: cfg_v = 7'($urandom_range(1, 6));
      endcase
      write_cfg(cdp_pkg::CFG_VAR_COUNT, cfg_v);
      nv = int'(cfg_v[4:0]);
      nv = (nv < 1) ? 1 : ((nv > cdp_pkg::NUM_VARS) ? cdp_pkg::NUM_VARS : nv);
      case ($urandom_range(11))
        0: cfg_v = 7'd0;
        1: cfg_v = 7'd127;
        2: cfg_v = 7'd64;
        default: cfg_v = 7'($urandom_range(1, 6));
      endcase
      write_cfg(cdp_pkg::CFG_CONS_COUNT, cfg_v);
      nc = int'(cfg_v);
      nc = (nc > cdp_pkg::NUM_CONS) ? cdp_pkg::NUM_CONS : nc;
      vmask = (nv >= 16) ? 16'hFFFF : ((16'd1 << nv) - 16'd1);

      // well-formed set: domains over the values in use
      for (int i = 0; i < nv; i++) begin
        case ($urandom_range(19))
          0: load_domain(6'(i), 16'($urandom));
          1: load_domain(6'(i), 16'h0000);
          default:
            load_domain(6'(i), (16'($urandom) & 16'($urandom) & vmask) |
                               (16'd1 << $urandom_range(nv - 1)));
        endcase
      end
      // constraints over the variables in use, up to eight rewritten per set
      for (int k = 0; k < nc && k < 8; k++) begin
        if ($urandom_range(9) == 0)
          load_cons(6'($urandom_range(63)), 2'($urandom), 4'($urandom),
                    5'($urandom), 16'($urandom));
        else
          load_cons(6'(k), 2'($urandom), 4'($urandom_range(nv - 1)),
                    5'($urandom_range(0, 3)), 16'($urandom) & vmask);
      end
      // noise
      if ($urandom_range(3) == 0) begin
        junk = rand_item();
        junk.func = 2'd3;
        send_beat(junk);
        load_domain(6'($urandom_range(16, 63)), 16'($urandom));
      end
      // hold off until the previous run has fully reported
      if (!paused && send_idle_pct == 84) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait (reports_due == 0);
        @(posedge clk);
        paused = 1;
      end
      run_prop();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (reports_due == 0);
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/cdp_pkg.sv
rtl/cdp_ctrl.sv
rtl/cdp_dp.sv
rtl/constraint_domain_propagator.sv
sim/propagation_checker.sv
sim/tb_top.sv
